// ===== src/llf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the Lax-Friedrichs face flux block.
// No dependencies; used by llf_isqrt, llf_mul and lee_lax_friedrichs_flux.
package llf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_LEFT,
        ST_SQ_RIGHT,
        ST_SPEED,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } llf_state_t;

    // One product per job; the order fixes the accumulation order.
    typedef enum logic [3:0] {
        JOB_MXL_CSQL,
        JOB_UL_PL,
        JOB_MXR_CSQR,
        JOB_UR_PR,
        JOB_RHOL_UL,
        JOB_RHOR_UR,
        JOB_MXL_UL,
        JOB_MXR_UR,
        JOB_DISS_P,
        JOB_DISS_RHO,
        JOB_DISS_MX,
        JOB_DISS_MY,
        JOB_DISS_MZ
    } llf_job_t;

    localparam llf_job_t JOB_LAST = JOB_DISS_MZ;

    localparam int NUM_FLUX = 5;
    localparam logic [2:0] TOT_PRESSURE = 3'd0;
    localparam logic [2:0] TOT_DENSITY  = 3'd1;
    localparam logic [2:0] TOT_MOM_X    = 3'd2;
    localparam logic [2:0] TOT_MOM_Y    = 3'd3;
    localparam logic [2:0] TOT_MOM_Z    = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } llf_unit_stat_t;

endpackage

// ===== src/llf_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one side of a face per transaction.
// Stand-alone; no package dependency.
interface llf_in_if #(parameter int DATA_WIDTH = 32) ();
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic signed [DATA_WIDTH-1:0] pressure;
    logic signed [DATA_WIDTH-1:0] density;
    logic signed [DATA_WIDTH-1:0] mom_x;
    logic signed [DATA_WIDTH-1:0] mom_y;
    logic signed [DATA_WIDTH-1:0] mom_z;
    logic        [DATA_WIDTH-1:0] base_c_squared;
    logic signed [DATA_WIDTH-1:0] base_vel_x;

    modport source (output valid, action, pressure, density, mom_x, mom_y, mom_z,
                    base_c_squared, base_vel_x, input ready);
    modport sink (input valid, action, pressure, density, mom_x, mom_y, mom_z,
                  base_c_squared, base_vel_x, output ready);
endinterface

// ===== src/llf_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: one face flux per transaction.
// Stand-alone; no package dependency.
interface llf_out_if #(parameter int DATA_WIDTH = 32) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] flux_pressure;
    logic signed [DATA_WIDTH-1:0] flux_density;
    logic signed [DATA_WIDTH-1:0] flux_mom_x;
    logic signed [DATA_WIDTH-1:0] flux_mom_y;
    logic signed [DATA_WIDTH-1:0] flux_mom_z;
    logic                         saturated;

    modport source (output valid, flux_pressure, flux_density, flux_mom_x, flux_mom_y,
                    flux_mom_z, saturated, input ready);
    modport sink (input valid, flux_pressure, flux_density, flux_mom_x, flux_mom_y,
                  flux_mom_z, saturated, output ready);
endinterface

// ===== src/llf_isqrt.sv =====
`timescale 1ns / 1ps
// Digit-serial integer square root of radicand * 2^F, one root bit per cycle.
// Depends on llf_pkg for the status struct.
module llf_isqrt #(
    parameter int W = 32,
    parameter int F = 16,
    localparam int RW = (W + F + 1) / 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [W-1:0]            radicand,
    output llf_pkg::llf_unit_stat_t stat,
    output logic [RW-1:0]           root
);
    localparam int NWE = 2 * RW;
    localparam int CW  = $clog2(RW + 1);

    logic [NWE-1:0] n_reg;
    logic [RW+2:0]  rem_reg;
    logic [RW-1:0]  root_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [RW+2:0]  rem_sh;
    logic [RW+2:0]  trial;
    logic           ge;

    assign rem_sh = {rem_reg[RW:0], n_reg[NWE-1:NWE-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= NWE'(radicand) << F;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg    <= {n_reg[NWE-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;
endmodule

// ===== src/llf_mul.sv =====
`timescale 1ns / 1ps
// Bit-serial signed multiplier, one multiplier bit per cycle, result floor(a*b / 2^F).
// Depends on llf_pkg for the status struct.
module llf_mul #(
    parameter int OW = 35,
    parameter int F  = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [OW-1:0]    a,
    input  logic signed [OW-1:0]    b,
    output llf_pkg::llf_unit_stat_t stat,
    output logic signed [2*OW:0]    prod
);
    localparam int CW = $clog2(OW + 1);

    logic [OW-1:0]   mcand_reg;
    logic [OW-1:0]   mplier_reg;
    logic [2*OW-1:0] acc_reg;
    logic            neg_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [OW:0]     sum;
    logic [2*OW:0]   q;
    logic            frac;

    assign sum = {1'b0, acc_reg[2*OW-1:OW]} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(OW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= a[OW-1] ? OW'(-a) : OW'(a);
            mplier_reg <= b[OW-1] ? OW'(-b) : OW'(b);
            neg_reg    <= a[OW-1] ^ b[OW-1];
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= {sum, acc_reg[OW-1:1]};
            mplier_reg <= mplier_reg >> 1;
        end
    end

    // Round toward minus infinity: a negative product with a remainder steps down one.
    assign q    = (2*OW+1)'(acc_reg >> F);
    assign frac = |acc_reg[F-1:0];
    assign prod = neg_reg ? $signed(-(q + (2*OW+1)'(frac))) : $signed(q);

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule

// ===== src/lee_lax_friedrichs_flux.sv =====
`timescale 1ns / 1ps
// Internal word widths: RW = ceil((DATA_WIDTH+FRAC_BITS)/2) for the roots,
// OW = max(DATA_WIDTH, RW+1) + 3 for the multiplier operands.
// Each face takes two roots on the bit-serial root unit and 13 products on the multiplier.
// One face at a time: no new transaction is accepted until the result is loaded for output.
// Asynchronous active-low reset clears control and zeroes the held left state.
module lee_lax_friedrichs_flux #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input logic      clk,
    input logic      rst_n,
    llf_in_if.sink   in_ch,
    llf_out_if.source out_ch
);
    localparam int W  = DATA_WIDTH;
    localparam int RW = (DATA_WIDTH + FRAC_BITS + 1) / 2;
    localparam int OW = ((W > RW + 1) ? W : RW + 1) + 3;
    localparam int SW = 2 * OW + 4;

    llf_pkg::llf_state_t state_reg, state_next;
    llf_pkg::llf_job_t   job_reg;

    logic signed [W-1:0] left_p_reg, left_rho_reg, left_mx_reg, left_my_reg, left_mz_reg;
    logic        [W-1:0] left_csq_reg;
    logic signed [W-1:0] left_u_reg;
    logic signed [W-1:0] right_p_reg, right_rho_reg, right_mx_reg, right_my_reg, right_mz_reg;
    logic        [W-1:0] right_csq_reg;
    logic signed [W-1:0] right_u_reg;

    logic [RW-1:0]        c_l_reg, c_r_reg;
    logic signed [OW-1:0] a_reg;
    logic signed [SW-1:0] tot_reg [llf_pkg::NUM_FLUX];
    logic signed [W-1:0]  fx_reg  [llf_pkg::NUM_FLUX];
    logic                 sat_reg;
    logic                 out_valid_reg;

    logic                    in_ready;
    logic                    in_fire;
    logic                    sq_start;
    logic [W-1:0]            sq_rad;
    llf_pkg::llf_unit_stat_t sq_stat;
    logic [RW-1:0]           sq_root;
    logic                    mul_start;
    llf_pkg::llf_unit_stat_t mul_stat;
    logic signed [2*OW:0]    mul_prod;
    logic signed [OW-1:0]    op_a, op_b;
    logic [2:0]              dest;
    logic                    sub;
    logic                    out_load;
    logic signed [OW-1:0]    a_new;
    logic signed [W-1:0]     fx_new [llf_pkg::NUM_FLUX];
    logic [llf_pkg::NUM_FLUX-1:0] clip;

    function automatic logic signed [OW-1:0] sx(input logic signed [W-1:0] v);
        return OW'(v);
    endfunction

    function automatic logic signed [OW-1:0] absv(input logic signed [OW-1:0] v);
        return v[OW-1] ? -v : v;
    endfunction

    assign in_fire = in_ch.valid && in_ready;

    llf_isqrt #(.W(W), .F(FRAC_BITS)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .stat     (sq_stat),
        .root     (sq_root)
    );

    llf_mul #(.OW(OW), .F(FRAC_BITS)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (op_a),
        .b     (op_b),
        .stat  (mul_stat),
        .prod  (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= llf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        sq_start   = 1'b0;
        sq_rad     = left_csq_reg;
        mul_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            llf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_ch.valid && in_ch.action)
                begin
                    sq_start   = 1'b1;
                    state_next = llf_pkg::ST_SQ_LEFT;
                end
            end
            llf_pkg::ST_SQ_LEFT:
            begin
                if (sq_stat.done)
                begin
                    sq_start   = 1'b1;
                    sq_rad     = right_csq_reg;
                    state_next = llf_pkg::ST_SQ_RIGHT;
                end
            end
            llf_pkg::ST_SQ_RIGHT:
            begin
                if (sq_stat.done)
                    state_next = llf_pkg::ST_SPEED;
            end
            llf_pkg::ST_SPEED:
                state_next = llf_pkg::ST_ISSUE;
            llf_pkg::ST_ISSUE:
            begin
                mul_start  = 1'b1;
                state_next = llf_pkg::ST_WAIT;
            end
            llf_pkg::ST_WAIT:
            begin
                if (mul_stat.done)
                    state_next = (job_reg == llf_pkg::JOB_LAST) ? llf_pkg::ST_FINISH
                                                                : llf_pkg::ST_ISSUE;
            end
            llf_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = llf_pkg::ST_IDLE;
                end
            end
            default:
                state_next = llf_pkg::ST_IDLE;
        endcase
    end

    // Operand and destination select for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        dest = llf_pkg::TOT_PRESSURE;
        sub  = 1'b0;
        unique case (job_reg)
            llf_pkg::JOB_MXL_CSQL:
            begin
                op_a = sx(left_mx_reg);
                op_b = OW'(left_csq_reg);
            end
            llf_pkg::JOB_UL_PL:
            begin
                op_a = sx(left_u_reg);
                op_b = sx(left_p_reg);
            end
            llf_pkg::JOB_MXR_CSQR:
            begin
                op_a = sx(right_mx_reg);
                op_b = OW'(right_csq_reg);
            end
            llf_pkg::JOB_UR_PR:
            begin
                op_a = sx(right_u_reg);
                op_b = sx(right_p_reg);
            end
            llf_pkg::JOB_RHOL_UL:
            begin
                op_a = sx(left_rho_reg);
                op_b = sx(left_u_reg);
                dest = llf_pkg::TOT_DENSITY;
            end
            llf_pkg::JOB_RHOR_UR:
            begin
                op_a = sx(right_rho_reg);
                op_b = sx(right_u_reg);
                dest = llf_pkg::TOT_DENSITY;
            end
            llf_pkg::JOB_MXL_UL:
            begin
                op_a = sx(left_mx_reg);
                op_b = sx(left_u_reg);
                dest = llf_pkg::TOT_MOM_X;
            end
            llf_pkg::JOB_MXR_UR:
            begin
                op_a = sx(right_mx_reg);
                op_b = sx(right_u_reg);
                dest = llf_pkg::TOT_MOM_X;
            end
            llf_pkg::JOB_DISS_P:
            begin
                op_a = a_reg;
                op_b = sx(right_p_reg) - sx(left_p_reg);
                sub  = 1'b1;
            end
            llf_pkg::JOB_DISS_RHO:
            begin
                op_a = a_reg;
                op_b = sx(right_rho_reg) - sx(left_rho_reg);
                dest = llf_pkg::TOT_DENSITY;
                sub  = 1'b1;
            end
            llf_pkg::JOB_DISS_MX:
            begin
                op_a = a_reg;
                op_b = sx(right_mx_reg) - sx(left_mx_reg);
                dest = llf_pkg::TOT_MOM_X;
                sub  = 1'b1;
            end
            llf_pkg::JOB_DISS_MY:
            begin
                op_a = a_reg;
                op_b = sx(right_my_reg) - sx(left_my_reg);
                dest = llf_pkg::TOT_MOM_Y;
                sub  = 1'b1;
            end
            llf_pkg::JOB_DISS_MZ:
            begin
                op_a = a_reg;
                op_b = sx(right_mz_reg) - sx(left_mz_reg);
                dest = llf_pkg::TOT_MOM_Z;
                sub  = 1'b1;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Wave speed: largest of |u0 - c| and |u0 + c| over both sides.
    always_comb
    begin
        logic signed [OW-1:0] v0, v1, v2, v3, m01, m23;
        v0    = absv(sx(left_u_reg) - OW'(c_l_reg));
        v1    = absv(sx(left_u_reg) + OW'(c_l_reg));
        v2    = absv(sx(right_u_reg) - OW'(c_r_reg));
        v3    = absv(sx(right_u_reg) + OW'(c_r_reg));
        m01   = (v0 > v1) ? v0 : v1;
        m23   = (v2 > v3) ? v2 : v3;
        a_new = (m01 > m23) ? m01 : m23;
    end

    // Halve with floor, then clip to the output range.
    always_comb
    begin
        logic signed [SW-1:0] h;
        for (int i = 0; i < llf_pkg::NUM_FLUX; i++)
        begin
            h = tot_reg[i] >>> 1;
            if (!h[SW-1] && (|h[SW-2:W-1]))
            begin
                fx_new[i] = {1'b0, {(W-1){1'b1}}};
                clip[i]   = 1'b1;
            end
            else if (h[SW-1] && !(&h[SW-2:W-1]))
            begin
                fx_new[i] = {1'b1, {(W-1){1'b0}}};
                clip[i]   = 1'b1;
            end
            else
            begin
                fx_new[i] = h[W-1:0];
                clip[i]   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_p_reg    <= '0;
            left_rho_reg  <= '0;
            left_mx_reg   <= '0;
            left_my_reg   <= '0;
            left_mz_reg   <= '0;
            left_csq_reg  <= '0;
            left_u_reg    <= '0;
            out_valid_reg <= 1'b0;
            job_reg       <= llf_pkg::JOB_MXL_CSQL;
        end
        else
        begin
            if (in_fire && !in_ch.action)
            begin
                left_p_reg   <= in_ch.pressure;
                left_rho_reg <= in_ch.density;
                left_mx_reg  <= in_ch.mom_x;
                left_my_reg  <= in_ch.mom_y;
                left_mz_reg  <= in_ch.mom_z;
                left_csq_reg <= in_ch.base_c_squared;
                left_u_reg   <= in_ch.base_vel_x;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == llf_pkg::ST_SPEED)
                job_reg <= llf_pkg::JOB_MXL_CSQL;
            else if (state_reg == llf_pkg::ST_WAIT && mul_stat.done
                     && job_reg != llf_pkg::JOB_LAST)
                job_reg <= llf_pkg::llf_job_t'(job_reg + 4'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.action)
        begin
            right_p_reg   <= in_ch.pressure;
            right_rho_reg <= in_ch.density;
            right_mx_reg  <= in_ch.mom_x;
            right_my_reg  <= in_ch.mom_y;
            right_mz_reg  <= in_ch.mom_z;
            right_csq_reg <= in_ch.base_c_squared;
            right_u_reg   <= in_ch.base_vel_x;
        end
        if (state_reg == llf_pkg::ST_SQ_LEFT && sq_stat.done)
            c_l_reg <= sq_root;
        if (state_reg == llf_pkg::ST_SQ_RIGHT && sq_stat.done)
            c_r_reg <= sq_root;
        if (state_reg == llf_pkg::ST_SPEED)
        begin
            a_reg <= a_new;
            tot_reg[llf_pkg::TOT_PRESSURE] <= '0;
            tot_reg[llf_pkg::TOT_DENSITY]  <= SW'(left_mx_reg) + SW'(right_mx_reg);
            tot_reg[llf_pkg::TOT_MOM_X]    <= SW'(left_p_reg) + SW'(right_p_reg);
            tot_reg[llf_pkg::TOT_MOM_Y]    <= '0;
            tot_reg[llf_pkg::TOT_MOM_Z]    <= '0;
        end
        else if (state_reg == llf_pkg::ST_WAIT && mul_stat.done)
        begin
            if (sub)
                tot_reg[dest] <= tot_reg[dest] - SW'(mul_prod);
            else
                tot_reg[dest] <= tot_reg[dest] + SW'(mul_prod);
        end
        if (out_load)
        begin
            for (int i = 0; i < llf_pkg::NUM_FLUX; i++)
                fx_reg[i] <= fx_new[i];
            sat_reg <= |clip;
        end
    end

    assign in_ch.ready          = in_ready;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.flux_pressure = fx_reg[llf_pkg::TOT_PRESSURE];
    assign out_ch.flux_density  = fx_reg[llf_pkg::TOT_DENSITY];
    assign out_ch.flux_mom_x    = fx_reg[llf_pkg::TOT_MOM_X];
    assign out_ch.flux_mom_y    = fx_reg[llf_pkg::TOT_MOM_Y];
    assign out_ch.flux_mom_z    = fx_reg[llf_pkg::TOT_MOM_Z];
    assign out_ch.saturated     = sat_reg;

    // Never restart the multiplier while a product is in flight.
    assert property (@(posedge clk) disable iff (!rst_n) mul_start |-> !mul_stat.busy)
        else $error("multiplier restarted while busy");

    // Root results arrive only while a root is awaited.
    assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.done |-> (state_reg == llf_pkg::ST_SQ_LEFT || state_reg == llf_pkg::ST_SQ_RIGHT))
        else $error("unexpected root result");

    // Finish only after the last product has been accumulated.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == llf_pkg::ST_FINISH |-> job_reg == llf_pkg::JOB_LAST)
        else $error("flux finished early");

    // A loaded result is offered on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) out_load |=> out_valid_reg)
        else $error("result lost on load");
endmodule

// ===== bench/lee_lax_friedrichs_flux_test.sv =====
`timescale 1ns / 1ps
// Testbench for lee_lax_friedrichs_flux: drives left/right face states, predicts each flux.
// Depends on src/llf_in_if.sv, src/llf_out_if.sv and src/lee_lax_friedrichs_flux.sv.
module lee_lax_friedrichs_flux_test;

    localparam int  W          = 32;
    localparam int  F          = 16;
    localparam int  TAIL       = 600;
    localparam longint LIMIT   = 3000000;
    localparam longint SAT_MAX = 64'sd2147483647;
    localparam longint SAT_MIN = -64'sd2147483648;
    localparam bit  ACT_LEFT   = 1'b0;
    localparam bit  ACT_RIGHT  = 1'b1;

    typedef struct {
        bit                  action;
        logic signed [W-1:0] pressure;
        logic signed [W-1:0] density;
        logic signed [W-1:0] mom_x;
        logic signed [W-1:0] mom_y;
        logic signed [W-1:0] mom_z;
        logic        [W-1:0] c_squared;
        logic signed [W-1:0] vel_x;
    } face_side_t;

    typedef struct {
        logic signed [W-1:0] fp;
        logic signed [W-1:0] frho;
        logic signed [W-1:0] fmx;
        logic signed [W-1:0] fmy;
        logic signed [W-1:0] fmz;
        logic                sat;
    } face_flux_t;

    logic clk;
    logic rst_n;
    llf_in_if  #(.DATA_WIDTH(W)) in_ch ();
    llf_out_if #(.DATA_WIDTH(W)) out_ch ();

    lee_lax_friedrichs_flux #(.DATA_WIDTH(W), .FRAC_BITS(F)) dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    face_side_t held_left;
    face_flux_t pending_flux[$];
    int         mismatches;
    longint     cycles;
    bit         stall_free;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ---- predictor ----
    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint q_mul(longint x, longint y);
        logic [63:0] m;
        logic [63:0] q;
        m = magnitude(x) * magnitude(y);
        q = m >> F;
        if ((x < 0) != (y < 0))
        begin
            if (m[F-1:0] != '0)
                q = q + 1;
            return -longint'(q);
        end
        return longint'(q);
    endfunction

    function automatic longint int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint widest_speed(longint a, longint u0, longint c);
        longint m;
        longint p;
        m = u0 - c;
        p = u0 + c;
        if (m < 0) m = -m;
        if (p < 0) p = -p;
        if (m > a) a = m;
        if (p > a) a = p;
        return a;
    endfunction

    function automatic logic [W-1:0] halve_clip(longint total, inout logic sat);
        longint h;
        h = total >>> 1;
        if (h > SAT_MAX)
        begin
            h = SAT_MAX;
            sat = 1'b1;
        end
        if (h < SAT_MIN)
        begin
            h = SAT_MIN;
            sat = 1'b1;
        end
        return h[W-1:0];
    endfunction

    function automatic face_flux_t rusanov_flux(face_side_t l, face_side_t r);
        face_flux_t f;
        longint pl, rl, mxl, myl, mzl, csql, ul;
        longint pr, rr, mxr, myr, mzr, csqr, ur;
        longint a, fpl, frl, ful, fpr, frr, fur;
        pl = l.pressure; rl = l.density; mxl = l.mom_x; myl = l.mom_y; mzl = l.mom_z;
        csql = longint'({32'd0, l.c_squared}); ul = l.vel_x;
        pr = r.pressure; rr = r.density; mxr = r.mom_x; myr = r.mom_y; mzr = r.mom_z;
        csqr = longint'({32'd0, r.c_squared}); ur = r.vel_x;
        a = widest_speed(0, ul, int_sqrt(64'(csql) << F));
        a = widest_speed(a, ur, int_sqrt(64'(csqr) << F));
        fpl = q_mul(mxl, csql) + q_mul(ul, pl);
        frl = mxl + q_mul(rl, ul);
        ful = pl + q_mul(mxl, ul);
        fpr = q_mul(mxr, csqr) + q_mul(ur, pr);
        frr = mxr + q_mul(rr, ur);
        fur = pr + q_mul(mxr, ur);
        f.sat  = 1'b0;
        f.fp   = halve_clip(fpl + fpr - q_mul(a, pr - pl), f.sat);
        f.frho = halve_clip(frl + frr - q_mul(a, rr - rl), f.sat);
        f.fmx  = halve_clip(ful + fur - q_mul(a, mxr - mxl), f.sat);
        f.fmy  = halve_clip(-q_mul(a, myr - myl), f.sat);
        f.fmz  = halve_clip(-q_mul(a, mzr - mzl), f.sat);
        return f;
    endfunction

    // ---- stimulus helpers ----
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Mostly shrink values so that many fluxes stay in range.
    function automatic logic [W-1:0] rand_word();
        logic [W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 3) != 0)
            v = $signed(v) >>> $urandom_range(4, 20);
        return v;
    endfunction

    function automatic face_side_t rand_side(bit act);
        face_side_t s;
        s.action    = act;
        s.pressure  = rand_word();
        s.density   = rand_word();
        s.mom_x     = rand_word();
        s.mom_y     = rand_word();
        s.mom_z     = rand_word();
        s.c_squared = $urandom;
        if ($urandom_range(0, 3) != 0)
            s.c_squared = s.c_squared >> $urandom_range(4, 24);
        s.vel_x     = rand_word();
        return s;
    endfunction

    function automatic face_side_t filled_side(bit act, logic [W-1:0] v, logic [W-1:0] c);
        face_side_t s;
        s.action = act;
        s.pressure = v; s.density = v; s.mom_x = v; s.mom_y = v; s.mom_z = v;
        s.c_squared = c;
        s.vel_x = v;
        return s;
    endfunction

    task automatic send_side(face_side_t s, int gap);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.action         = s.action;
        in_ch.pressure       = s.pressure;
        in_ch.density        = s.density;
        in_ch.mom_x          = s.mom_x;
        in_ch.mom_y          = s.mom_y;
        in_ch.mom_z          = s.mom_z;
        in_ch.base_c_squared = s.c_squared;
        in_ch.base_vel_x     = s.vel_x;
        in_ch.valid          = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (s.action == ACT_LEFT)
            held_left = s;
        else
            pending_flux.push_back(rusanov_flux(held_left, s));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pending_flux.size() != 0)
            @(negedge clk);
    endtask

    // ---- tests ----
    task automatic test_directed();
        // Right side straight after reset uses the zeroed left state.
        send_side(filled_side(ACT_RIGHT, 32'h0001_0000, 32'h0004_0000), 0);
        send_side(filled_side(ACT_LEFT, 32'h7fff_ffff, 32'hffff_ffff), 0);
        send_side(filled_side(ACT_RIGHT, 32'h8000_0000, 32'hffff_ffff), 0);
        send_side(filled_side(ACT_RIGHT, 32'h8000_0000, 32'h0000_0000), 1);
        send_side(filled_side(ACT_LEFT, 32'h8000_0000, 32'h0000_0000), 0);
        send_side(filled_side(ACT_RIGHT, 32'h7fff_ffff, 32'h0000_0000), 0);
        send_side(filled_side(ACT_LEFT, 32'h0000_0000, 32'h0000_0000), 0);
        send_side(filled_side(ACT_RIGHT, 32'h0000_0000, 32'h0000_0000), 0);
        send_side(filled_side(ACT_LEFT, 32'hffff_ffff, 32'h0000_0001), 2);
        send_side(filled_side(ACT_RIGHT, 32'h0000_0001, 32'h0001_0000), 0);
        // Overwritten left state: only the second store counts.
        send_side(filled_side(ACT_LEFT, 32'h1234_5678, 32'h0010_0000), 0);
        send_side(filled_side(ACT_LEFT, 32'hfffe_0000, 32'h0002_0000), 0);
        send_side(filled_side(ACT_RIGHT, 32'h0003_8000, 32'h0009_0000), 0);
        // Repeat compute against the same held left state.
        send_side(filled_side(ACT_RIGHT, 32'hffff_8000, 32'h0001_0000), 0);
        send_side(filled_side(ACT_LEFT, 32'h5555_5555, 32'haaaa_aaaa), 0);
        send_side(filled_side(ACT_RIGHT, 32'haaaa_aaaa, 32'h5555_5555), 0);
    endtask

    task automatic test_random_faces(int n);
        int sent;
        int r;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                send_side(rand_side(ACT_LEFT), pick_gap());
                send_side(rand_side(ACT_RIGHT), pick_gap());
                sent += 2;
            end
            else
            begin
                send_side(rand_side(r < 90 ? ACT_LEFT : ACT_RIGHT), pick_gap());
                sent += 1;
            end
        end
    endtask

    task automatic test_drain_pause();
        send_side(rand_side(ACT_LEFT), 0);
        send_side(rand_side(ACT_RIGHT), 0);
        wait_drained();
        send_side(rand_side(ACT_RIGHT), 0);
    endtask

    // ---- output ready and checking ----
    initial
    begin
        out_ch.ready = 1'b0;
        stall_free = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                stall_free = !stall_free;
            if (stall_free || $urandom_range(0, 2) != 0)
                out_ch.ready = 1'b1;
            else
            begin
                out_ch.ready = 1'b0;
                repeat (pick_gap()) @(negedge clk);
                out_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        face_flux_t exp_f;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_flux.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected flux transaction at cycle %0d", cycles);
            end
            else
            begin
                exp_f = pending_flux.pop_front();
                if (out_ch.flux_pressure !== exp_f.fp || out_ch.flux_density !== exp_f.frho
                    || out_ch.flux_mom_x !== exp_f.fmx || out_ch.flux_mom_y !== exp_f.fmy
                    || out_ch.flux_mom_z !== exp_f.fmz || out_ch.saturated !== exp_f.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("flux mismatch cycle %0d: exp %h %h %h %h %h %b got %h %h %h %h %h %b",
                                 cycles, exp_f.fp, exp_f.frho, exp_f.fmx, exp_f.fmy, exp_f.fmz,
                                 exp_f.sat, out_ch.flux_pressure, out_ch.flux_density,
                                 out_ch.flux_mom_x, out_ch.flux_mom_y, out_ch.flux_mom_z,
                                 out_ch.saturated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        cycles = 0;
        mismatches = 0;
        held_left = filled_side(ACT_LEFT, '0, '0);
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_LEFT;
        in_ch.pressure = '0;
        in_ch.density = '0;
        in_ch.mom_x = '0;
        in_ch.mom_y = '0;
        in_ch.mom_z = '0;
        in_ch.base_c_squared = '0;
        in_ch.base_vel_x = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_faces(540);
        test_drain_pause();
        test_random_faces(540);

        wait_drained();
        repeat (TAIL) @(posedge clk);
        if (mismatches == 0 && pending_flux.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
